>>> rtl/gsaf_pkg.sv
package gsaf_pkg;

  // Direction class of a square as seen from the turret square.
  typedef enum logic [3:0] {
    DIR_CENTER,
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT,
    QUAD_UR,
    QUAD_DR,
    QUAD_DL,
    QUAD_UL
  } dir_t;

  // One classified beat, as passed from the front end to the back end.
  typedef struct packed {
    logic [9:0]  square_id;
    logic        in_range;
    dir_t        dir;
    logic [4:0]  ax;
    logic [4:0]  ay;
    logic [10:0] dist_sq;
  } item_t;

  localparam int GridW      = 5;
  localparam int RootW      = 22;
  localparam int RemW       = 24;
  localparam int VecW       = 24;
  localparam int AngW       = 25;
  localparam int SqrtSteps  = 22;
  localparam int CordicIter = 20;
  localparam int KW         = 23;

  // Angle constants in degrees with 16 fraction bits.
  localparam logic [AngW-1:0] Deg90  = 25'd5898240;
  localparam logic [AngW-1:0] Deg180 = 25'd11796480;
  localparam logic [AngW-1:0] Deg270 = 25'd17694720;
  localparam logic [AngW-1:0] Deg360 = 25'd23592960;

  // Flow: (2.27*d + 1.69) in Q8.8, rounded half up.
  localparam logic [7:0]  FlowGain   = 8'd227;
  localparam logic [29:0] FlowOffset = 30'd11088384;
  // Reciprocals for constant division: 100 (shift 29), 45 (shift 36), 10 (shift 25).
  localparam logic [22:0] Recip100   = 23'd5368710;
  localparam logic [30:0] Recip45    = 31'd1527099484;
  localparam logic [21:0] Recip10    = 22'd3355444;
  localparam logic [12:0] CenterSteps = 13'd999;

  // Arctangent of 2^-i in degrees, 16 fraction bits.
  function automatic logic [VecW-1:0] atan_deg(input int i);
    logic [VecW-1:0] v;
    case (i)
      0:       v = 24'd2949120;
      1:       v = 24'd1740967;
      2:       v = 24'd919879;
      3:       v = 24'd466945;
      4:       v = 24'd234379;
      5:       v = 24'd117304;
      6:       v = 24'd58666;
      7:       v = 24'd29335;
      8:       v = 24'd14668;
      9:       v = 24'd7334;
      10:      v = 24'd3667;
      11:      v = 24'd1833;
      12:      v = 24'd917;
      13:      v = 24'd458;
      14:      v = 24'd229;
      15:      v = 24'd115;
      16:      v = 24'd57;
      17:      v = 24'd29;
      18:      v = 24'd14;
      19:      v = 24'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/gsaf_front.sv
module gsaf_front import gsaf_pkg::*; #(
  parameter int MAX_GRID = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [GridW-1:0] cfg_wdata,
  input  logic             accept,
  input  logic [GridW-1:0] column,
  input  logic [GridW-1:0] row,
  input  logic             push_ok,
  output logic             item_valid,
  output item_t            item
);

  localparam logic [GridW-1:0] GridMax = GridW'(MAX_GRID);

  logic [GridW-1:0] grid_size;
  logic [GridW-1:0] g;
  logic [3:0]       t;
  logic signed [6:0] dx, dy;
  logic [4:0]       ax, ay;
  logic [9:0]       pos;
  item_t            item_next;

  // Grid size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= 5'd25;
    end else if (cfg_we) begin
      grid_size <= cfg_wdata;
    end
  end

  // Classify the square against the turret square.
  always_comb begin
    if (grid_size == '0) begin
      g = 5'd1;
    end else if (grid_size > GridMax) begin
      g = GridMax;
    end else begin
      g = grid_size;
    end
    t   = 4'((g - 5'd1) >> 1);
    dx  = $signed({2'b00, column}) - $signed({3'b000, t});
    dy  = $signed({2'b00, row}) - $signed({3'b000, t});
    ax  = dx[6] ? 5'(-dx) : dx[4:0];
    ay  = dy[6] ? 5'(-dy) : dy[4:0];
    pos = 10'(row * g) + 10'(column);
    item_next.square_id = 10'd624 - pos;
    item_next.in_range  = (column < g) && (row < g);
    item_next.ax        = ax;
    item_next.ay        = ay;
    item_next.dist_sq   = 11'(ax * ax) + 11'(ay * ay);
    if (dx == 0 && dy == 0) begin
      item_next.dir = DIR_CENTER;
    end else if (dx == 0) begin
      item_next.dir = dy[6] ? DIR_UP : DIR_DOWN;
    end else if (dy == 0) begin
      item_next.dir = dx[6] ? DIR_LEFT : DIR_RIGHT;
    end else if (!dx[6]) begin
      item_next.dir = dy[6] ? QUAD_UR : QUAD_DR;
    end else begin
      item_next.dir = dy[6] ? QUAD_UL : QUAD_DL;
    end
  end

  // Holding register; it empties into the queue when there is room.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= accept | (item_valid & ~push_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

>>> rtl/gsaf_queue.sv
module gsaf_queue import gsaf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  // The back end never stalls, so every stored beat leaves at once.
  assign pop  = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      count     <= 2'd0;
      pop_valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count     <= count + 2'(push) - 2'(pop);
      pop_valid <= pop;
    end
  end

  // Storage, written and read with registered data.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
    pop_item <= mem[rd_ptr];
  end

endmodule

>>> rtl/gsaf_back.sv
module gsaf_back import gsaf_pkg::*; #(
  parameter int STEPS_PER_TURN = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        done,
  output logic [9:0]  square_id,
  output logic [15:0] flow_q8_8,
  output logic [12:0] step_count,
  output logic        at_center,
  output logic        in_range
);

  localparam logic [21:0] StepScale = 22'(STEPS_PER_TURN * 1000);

  typedef struct packed {
    logic                   vld;
    logic [9:0]             square_id;
    logic                   in_range;
    dir_t                   dir;
    logic [10:0]            dist_sq;
    logic [RemW-1:0]        rem;
    logic [RootW-1:0]       root;
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
    logic signed [VecW-1:0] z;
  } arith_t;

  arith_t a_reg [SqrtSteps];

  // Square root (two radicand bits a stage) and CORDIC run side by side.
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_arith
    arith_t a_in;
    arith_t a_out;
    logic [11:0]           rad_hi;
    logic [1:0]            pair;
    logic [RemW+1:0]       rem_sh;
    logic [RemW+1:0]       trial;
    logic signed [VecW-1:0] sx, sy;

    if (j == 0) begin : g_first
      always_comb begin
        a_in           = '0;
        a_in.vld       = in_valid;
        a_in.square_id = in_item.square_id;
        a_in.in_range  = in_item.in_range;
        a_in.dir       = in_item.dir;
        a_in.dist_sq   = in_item.dist_sq;
        a_in.vx        = $signed({3'b000, in_item.ay, 16'h0000});
        a_in.vy        = $signed({3'b000, in_item.ax, 16'h0000});
      end
    end else begin : g_rest
      assign a_in = a_reg[j-1];
    end

    always_comb begin
      a_out  = a_in;
      rad_hi = {1'b0, a_in.dist_sq};
      if (j < 6) begin
        pair = rad_hi[11-2*(j%6) -: 2];
      end else begin
        pair = 2'b00;
      end
      rem_sh = {a_in.rem, pair};
      trial  = (RemW+2)'({a_in.root, 2'b01});
      if (rem_sh >= trial) begin
        a_out.rem  = RemW'(rem_sh - trial);
        a_out.root = {a_in.root[RootW-2:0], 1'b1};
      end else begin
        a_out.rem  = RemW'(rem_sh);
        a_out.root = {a_in.root[RootW-2:0], 1'b0};
      end
      sx = a_in.vx >>> (j % CordicIter);
      sy = a_in.vy >>> (j % CordicIter);
      if (j < CordicIter) begin
        if (!a_in.vy[VecW-1]) begin
          a_out.vx = a_in.vx + sy;
          a_out.vy = a_in.vy - sx;
          a_out.z  = a_in.z + $signed(atan_deg(j));
        end else begin
          a_out.vx = a_in.vx - sy;
          a_out.vy = a_in.vy + sx;
          a_out.z  = a_in.z - $signed(atan_deg(j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_reg[j].vld <= 1'b0;
      end else begin
        a_reg[j].vld <= a_out.vld;
      end
    end

    always_ff @(posedge clk) begin
      a_reg[j].square_id <= a_out.square_id;
      a_reg[j].in_range  <= a_out.in_range;
      a_reg[j].dir       <= a_out.dir;
      a_reg[j].dist_sq   <= a_out.dist_sq;
      a_reg[j].rem       <= a_out.rem;
      a_reg[j].root      <= a_out.root;
      a_reg[j].vx        <= a_out.vx;
      a_reg[j].vy        <= a_out.vy;
      a_reg[j].z         <= a_out.z;
    end
  end

  arith_t           a_last;
  logic [AngW-1:0]  a_clamp;
  logic [AngW-1:0]  ang_next;

  assign a_last = a_reg[SqrtSteps-1];

  // Clamp the CORDIC angle and fold it into the right quadrant.
  always_comb begin
    if (a_last.z[VecW-1]) begin
      a_clamp = '0;
    end else if (AngW'(a_last.z) > Deg90) begin
      a_clamp = Deg90;
    end else begin
      a_clamp = AngW'(a_last.z);
    end
    unique case (a_last.dir)
      DIR_CENTER: ang_next = '0;
      DIR_UP:     ang_next = '0;
      DIR_DOWN:   ang_next = Deg180;
      DIR_LEFT:   ang_next = Deg270;
      DIR_RIGHT:  ang_next = Deg90;
      QUAD_UR:    ang_next = a_clamp;
      QUAD_DR:    ang_next = Deg180 - a_clamp;
      QUAD_DL:    ang_next = Deg180 + a_clamp;
      QUAD_UL:    ang_next = Deg360 - a_clamp;
      default:    ang_next = '0;
    endcase
  end

  logic [5:0]  vld;
  logic [9:0]  sid  [6];
  logic        rng  [6];
  logic        ctr  [6];
  logic [29:0] flow_x;
  logic [15:0] flow_q1, flow_q2, flow_q3, flow_q4;
  logic [AngW-1:0] ang;
  logic [27:0] ang_scaled;
  logic [KW-1:0] k2, k3, k4, k5;
  logic [44:0] flow_prod;
  logic [46:0] ang_prod;
  logic [58:0] div45_prod;
  logic [44:0] r1_prod, r2_prod, r3_prod;

  assign flow_prod  = 45'(flow_x[29:8]) * 45'(Recip100);
  assign ang_prod   = 47'(ang) * 47'(StepScale);
  assign div45_prod = 59'(ang_scaled) * 59'(Recip45);
  // Round half up one decimal digit: floor((k + 5) / 10).
  assign r1_prod    = 45'(k2 + KW'(5)) * 45'(Recip10);
  assign r2_prod    = 45'(k3 + KW'(5)) * 45'(Recip10);
  assign r3_prod    = 45'(k4 + KW'(5)) * 45'(Recip10);

  // Valid bits of the finishing stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[4:0], a_last.vld};
    end
  end

  // Sideband travels alongside the finishing stages.
  always_ff @(posedge clk) begin
    sid[0] <= a_last.square_id;
    rng[0] <= a_last.in_range;
    ctr[0] <= (a_last.dir == DIR_CENTER);
    for (int i = 1; i < 6; i++) begin
      sid[i] <= sid[i-1];
      rng[i] <= rng[i-1];
      ctr[i] <= ctr[i-1];
    end
  end

  // Flow and step arithmetic, one multiplier between registers.
  always_ff @(posedge clk) begin
    flow_x     <= 30'(a_last.root * FlowGain) + FlowOffset;
    ang        <= ang_next;
    flow_q1    <= 16'(flow_prod >> 29);
    ang_scaled <= 28'(ang_prod >> 19);
    flow_q2    <= flow_q1;
    k2         <= KW'(div45_prod >> 36);
    flow_q3    <= flow_q2;
    k3         <= KW'(r1_prod >> 25);
    flow_q4    <= flow_q3;
    k4         <= KW'(r2_prod >> 25);
    flow_q8_8  <= flow_q4;
    k5         <= KW'(r3_prod >> 25);
  end

  assign done       = vld[5];
  assign square_id  = sid[5];
  assign in_range   = rng[5];
  assign at_center  = ctr[5];
  assign step_count = ctr[5] ? CenterSteps : k5[12:0];

endmodule

>>> rtl/grid_square_aim_and_flow_unit.sv
// Takes one grid square per beat on start and returns its square id, water flow
// in Q8.8 and motor step count from home, all relative to the turret square at
// the centre of a grid_size by grid_size grid. A new square can be started on
// every clock cycle; each result appears on done for one cycle, in the order the
// squares came in. A square passes the front-end holding register, the queue's
// storage and its registered read, the 22-stage square-root pipeline and six
// stages of flow and step arithmetic. The result side cannot be held off,
// so busy stays low in use.
// grid_size should be written only while no square is in flight.
module grid_square_aim_and_flow_unit import gsaf_pkg::*; #(
  parameter int STEPS_PER_TURN = 200,
  parameter int MAX_GRID       = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  column,
  input  logic [4:0]  row,
  output logic        done,
  output logic [9:0]  square_id,
  output logic [15:0] flow_q8_8,
  output logic [12:0] step_count,
  output logic        at_center,
  output logic        in_range
);

  logic  accept;
  logic  item_valid;
  item_t item;
  logic  q_full;
  logic  push;
  logic  pop_valid;
  item_t pop_item;

  assign busy   = item_valid & q_full;
  assign accept = start & ~busy;
  assign push   = item_valid & ~q_full;

  // Front end: takes and classifies a square.
  gsaf_front #(
    .MAX_GRID(MAX_GRID)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .column    (column),
    .row       (row),
    .push_ok   (~q_full),
    .item_valid(item_valid),
    .item      (item)
  );

  // Short queue between the two halves.
  gsaf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(item),
    .full     (q_full),
    .pop_valid(pop_valid),
    .pop_item (pop_item)
  );

  // Back end: distance, angle, flow and step count.
  gsaf_back #(
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_item   (pop_item),
    .done      (done),
    .square_id (square_id),
    .flow_q8_8 (flow_q8_8),
    .step_count(step_count),
    .at_center (at_center),
    .in_range  (in_range)
  );

`ifndef SYNTHESIS
  // The turret square always reports the fixed step code.
  assert property (@(posedge clk) disable iff (rst)
    done && at_center |-> step_count == 13'd999)
    else $error("center square with wrong step count");

  // At zero distance the flow is the bare offset.
  assert property (@(posedge clk) disable iff (rst)
    done && at_center |-> flow_q8_8 == 16'd433)
    else $error("center square with wrong flow");

  // Coming out of reset the block is ready at once.
  assert property (@(posedge clk)
    $past(rst) |-> !busy && !done)
    else $error("busy or done right after reset");
`endif

endmodule

>>> bench/tb.sv
module tb;
  import gsaf_pkg::*;

  typedef struct {
    logic [9:0]  square_id;
    logic [15:0] flow_q8_8;
    logic [12:0] step_count;
    logic        at_center;
    logic        in_range;
  } aim_t;

  // Expected aim and flow results, oldest first, against the grid size in force.
  class aim_scoreboard;
    aim_t pending[$];
    int   grid;
    int   errors;

    function new();
      grid = 25;
      errors = 0;
    endfunction

    // Integer square root of a 64-bit value.
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint fshift(longint v, int sh);
      if (v >= 0) return v >>> sh;
      return ~((~v) >>> sh);
    endfunction

    // Arctangent of num/den in degrees with 16 fraction bits, by vectoring CORDIC.
    function longint arctan_deg(longint num, longint den);
      longint vx, vy, z, sx, sy;
      vx = den * 65536;
      vy = num * 65536;
      z = 0;
      for (int i = 0; i < CordicIter; i++) begin
        sx = fshift(vx, i);
        sy = fshift(vy, i);
        if (vy >= 0) begin
          vx += sy; vy -= sx; z += longint'(atan_deg(i));
        end else begin
          vx -= sy; vy += sx; z -= longint'(atan_deg(i));
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return z;
    endfunction

    // Notes an accepted square and works out its result.
    function void note_square(int col, int rw);
      aim_t e;
      longint g, t, dx, dy, ax, ay, ang, a;
      longint unsigned s, r, flow, k;
      g = grid;
      if (g < 1) g = 1;
      if (g > 25) g = 25;
      t = (g - 1) / 2;
      dx = col - t;
      dy = rw - t;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      s = ax * ax + ay * ay;
      r = int_sqrt(s << 32);
      flow = (r * 227 + 169 * 65536 + 12800) / 25600;
      if (flow > 65535) flow = 65535;
      e.at_center = (dx == 0 && dy == 0);
      if (e.at_center) begin
        k = 999;
      end else begin
        if (dx == 0) ang = dy < 0 ? 0 : 180 * 65536;
        else if (dy == 0) ang = dx < 0 ? 270 * 65536 : 90 * 65536;
        else begin
          a = arctan_deg(ax, ay);
          if (dx > 0) ang = dy < 0 ? a : 180 * 65536 - a;
          else ang = dy > 0 ? 180 * 65536 + a : 360 * 65536 - a;
        end
        k = (longint'(ang) * 200 * 1000) / (360 * 65536);
        for (int i = 0; i < 3; i++) begin
          if (k % 10 > 4) k = k / 10 + 1;
          else k = k / 10;
        end
      end
      e.square_id = 10'(624 - (rw * g + col));
      e.flow_q8_8 = flow[15:0];
      e.step_count = k[12:0];
      e.in_range = (col < g && rw < g);
      pending.push_back(e);
    endfunction

    // Compares one result beat with the oldest expectation.
    function void check_result(aim_t got);
      aim_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing expected, square_id %0d", $time, got.square_id);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.square_id !== e.square_id) begin
        $display("%0t: square_id expected %0d actual %0d", $time, e.square_id, got.square_id);
        errors++;
      end
      if (got.flow_q8_8 !== e.flow_q8_8) begin
        $display("%0t: flow_q8_8 expected %0d actual %0d", $time, e.flow_q8_8, got.flow_q8_8);
        errors++;
      end
      if (got.step_count !== e.step_count) begin
        $display("%0t: step_count expected %0d actual %0d", $time, e.step_count,
                 got.step_count);
        errors++;
      end
      if (got.at_center !== e.at_center) begin
        $display("%0t: at_center expected %0b actual %0b", $time, e.at_center, got.at_center);
        errors++;
      end
      if (got.in_range !== e.in_range) begin
        $display("%0t: in_range expected %0b actual %0b", $time, e.in_range, got.in_range);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [4:0]  cfg_wdata = '0;
  logic        start = 0;
  logic        busy;
  logic [4:0]  column = '0;
  logic [4:0]  row = '0;
  logic        done;
  logic [9:0]  square_id;
  logic [15:0] flow_q8_8;
  logic [12:0] step_count;
  logic        at_center;
  logic        in_range;

  aim_scoreboard sb = new();
  longint cycles = 0;
  localparam longint CycleLimit = 200000;

  always #2 clk = ~clk;

  grid_square_aim_and_flow_unit u_dut (
    .clk, .rst, .cfg_we, .cfg_wdata, .start, .busy, .column, .row,
    .done, .square_id, .flow_q8_8, .step_count, .at_center, .in_range
  );

  // Result beats are taken at the rising edge; inputs are accepted there too.
  always @(posedge clk) begin
    aim_t got;
    cycles <= cycles + 1;
    if (!rst && done) begin
      got.square_id = square_id;
      got.flow_q8_8 = flow_q8_8;
      got.step_count = step_count;
      got.at_center = at_center;
      got.in_range = in_range;
      sb.check_result(got);
    end
    if (!rst && start && !busy) sb.note_square(column, row);
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one square, after a random idle gap when allowed, and holds it until a beat is taken.
  task automatic send_square(int col, int rw, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start <= 1;
    column <= col[4:0];
    row <= rw[4:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Lets the pipeline empty out completely.
  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_grid(int g);
    cfg_we <= 1;
    cfg_wdata <= g[4:0];
    @(negedge clk);
    cfg_we <= 0;
    sb.grid = g;
  endtask

  initial begin
    int grids[8];
    int g;
    grids = '{25, 1, 0, 31, 2, 26, 24, 7};
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: centre, axes, quadrants, corners and out-of-grid squares.
    send_square(12, 12, 0);
    send_square(12, 0, 0);
    send_square(12, 24, 0);
    send_square(0, 12, 0);
    send_square(24, 12, 0);
    send_square(24, 0, 0);
    send_square(24, 24, 0);
    send_square(0, 24, 0);
    send_square(0, 0, 0);
    send_square(13, 11, 0);
    send_square(31, 31, 0);
    send_square(25, 3, 0);
    send_square(3, 30, 0);
    drain();

    // Random phases over several grid sizes.
    foreach (grids[p]) begin
      set_grid(grids[p]);
      g = grids[p] < 1 ? 1 : (grids[p] > 25 ? 25 : grids[p]);
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(0, 7) == 0)
          send_square($urandom_range(0, 31), $urandom_range(0, 31), p < 6);
        else
          send_square($urandom_range(0, g - 1), $urandom_range(0, g - 1), p < 6);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
